/* hw/rtl/mipsalu_pkg.sv */
// ----------------------------------------------------------------------------
// mipsalu_pkg
// opcode and function codes for the integer alu execute block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mipsalu_pkg;

    localparam int unsigned XLEN      = 32;
    localparam int unsigned REG_COUNT = 32;
    localparam int unsigned REG_IDX_W = 5;

    typedef logic [XLEN-1:0]      word_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [5:0]           code_t;

    // primary opcodes
    localparam code_t OP_SPECIAL = 6'h00;
    localparam code_t OP_ADDIU   = 6'h09;
    localparam code_t OP_SLTI    = 6'h0A;
    localparam code_t OP_SLTIU   = 6'h0B;
    localparam code_t OP_ANDI    = 6'h0C;
    localparam code_t OP_ORI     = 6'h0D;
    localparam code_t OP_XORI    = 6'h0E;
    localparam code_t OP_LUI     = 6'h0F;

    // special function codes
    localparam code_t FN_SLL  = 6'h00;
    localparam code_t FN_SRL  = 6'h02;
    localparam code_t FN_SRA  = 6'h03;
    localparam code_t FN_ADDU = 6'h21;
    localparam code_t FN_SUBU = 6'h23;
    localparam code_t FN_AND  = 6'h24;
    localparam code_t FN_OR   = 6'h25;
    localparam code_t FN_XOR  = 6'h26;
    localparam code_t FN_NOR  = 6'h27;
    localparam code_t FN_SLT  = 6'h2A;
    localparam code_t FN_SLTU = 6'h2B;

    localparam word_t PC_STEP = 32'd4;

endpackage

`default_nettype wire

/* hw/rtl/mips_integer_alu_execute.sv */
// ----------------------------------------------------------------------------
// mips_integer_alu_execute
// decodes and executes the integer alu subset on a 32-entry register file
// ----------------------------------------------------------------------------
// One instruction beat in, one result beat out. The block takes a new beat
// every cycle unless the output stalls; execute and output are registered. The
// register file is a synchronous memory with two read ports (rs, rt) read
// at input accept and one write port written as a result leaves execute;
// a write in the same cycle as the next read is forwarded. Register file
// entries read as zero until first written, so no clearing pass is needed
// after reset. Unsupported words leave regfile and retired count unchanged.
`timescale 1ns / 1ps
`default_nettype none

module mips_integer_alu_execute import mipsalu_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_instruction_word,
    input  wire logic [31:0] s_instruction_address,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_supported,
    output logic             m_wrote,
    output logic [4:0]       m_dest_index,
    output logic [31:0]      m_dest_value,
    output logic [31:0]      m_next_address,
    output logic [31:0]      m_retired_total
);

    word_t                  regfile_mem [REG_COUNT];
    logic [REG_COUNT-1:0]   written_reg;

    logic     ex_valid_reg;
    word_t    ex_word_reg;
    word_t    ex_addr_reg;
    word_t    rd_a_reg;
    word_t    rd_b_reg;
    logic     rd_a_vld_reg;
    logic     rd_b_vld_reg;
    logic     fwd_a_reg;
    logic     fwd_b_reg;
    word_t    fwd_val_reg;

    word_t    retired_reg;
    word_t    retired_next;

    logic     out_valid_reg;
    logic     out_supported_reg;
    logic     out_wrote_reg;
    reg_idx_t out_dest_reg;
    word_t    out_value_reg;
    word_t    out_next_addr_reg;
    word_t    out_retired_reg;

    logic     s_fire;
    logic     ex_advance;
    reg_idx_t in_rs;
    reg_idx_t in_rt;

    code_t    primary;
    code_t    funct;
    reg_idx_t ex_rt;
    reg_idx_t ex_rd;
    reg_idx_t shamt;
    logic [15:0] imm;
    word_t    zimm;
    word_t    simm;
    word_t    op_a;
    word_t    op_b;
    logic     ok;
    reg_idx_t dest;
    word_t    val;
    logic     wr_en;

    assign in_rs = s_instruction_word[25:21];
    assign in_rt = s_instruction_word[20:16];

    assign ex_advance = ex_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !ex_valid_reg || ex_advance;
    assign s_fire     = s_valid && s_ready;

    // execute
    assign primary = ex_word_reg[31:26];
    assign ex_rt   = ex_word_reg[20:16];
    assign ex_rd   = ex_word_reg[15:11];
    assign shamt   = ex_word_reg[10:6];
    assign funct   = ex_word_reg[5:0];
    assign imm     = ex_word_reg[15:0];
    assign zimm    = {16'h0000, imm};
    assign simm    = {{16{imm[15]}}, imm};

    always_comb begin
        if (fwd_a_reg) begin
            op_a = fwd_val_reg;
        end else begin
            op_a = rd_a_vld_reg ? rd_a_reg : '0;
        end
        if (fwd_b_reg) begin
            op_b = fwd_val_reg;
        end else begin
            op_b = rd_b_vld_reg ? rd_b_reg : '0;
        end
    end

    always_comb begin
        ok   = 1'b1;
        dest = '0;
        val  = '0;
        if (ex_word_reg == '0) begin
            dest = '0;
        end else if (primary == OP_SPECIAL) begin
            dest = ex_rd;
            case (funct)
                FN_SLL:  val = op_b << shamt;
                FN_SRL:  val = op_b >> shamt;
                FN_SRA:  val = word_t'($signed(op_b) >>> shamt);
                FN_ADDU: val = op_a + op_b;
                FN_SUBU: val = op_a - op_b;
                FN_AND:  val = op_a & op_b;
                FN_OR:   val = op_a | op_b;
                FN_XOR:  val = op_a ^ op_b;
                FN_NOR:  val = ~(op_a | op_b);
                FN_SLT:  val = {31'd0, $signed(op_a) < $signed(op_b)};
                FN_SLTU: val = {31'd0, op_a < op_b};
                default: ok = 1'b0;
            endcase
        end else begin
            dest = ex_rt;
            case (primary)
                OP_ADDIU: val = op_a + simm;
                OP_SLTI:  val = {31'd0, $signed(op_a) < $signed(simm)};
                OP_SLTIU: val = {31'd0, op_a < simm};
                OP_ANDI:  val = op_a & zimm;
                OP_ORI:   val = op_a | zimm;
                OP_XORI:  val = op_a ^ zimm;
                OP_LUI:   val = {imm, 16'h0000};
                default:  ok = 1'b0;
            endcase
        end
        if (!ok) begin
            dest = '0;
            val  = '0;
        end
    end

    assign wr_en        = ex_advance && ok && (dest != '0);
    assign retired_next = retired_reg + word_t'(ok);

    // register file memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            regfile_mem[dest] <= val;
        end
        if (s_fire) begin
            rd_a_reg <= regfile_mem[in_rs];
            rd_b_reg <= regfile_mem[in_rt];
        end
    end

    // control and payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg   <= '0;
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            retired_reg   <= '0;
            fwd_a_reg     <= 1'b0;
            fwd_b_reg     <= 1'b0;
            rd_a_vld_reg  <= 1'b0;
            rd_b_vld_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[dest] <= 1'b1;
            end
            if (s_fire) begin
                ex_valid_reg <= 1'b1;
                rd_a_vld_reg <= written_reg[in_rs];
                rd_b_vld_reg <= written_reg[in_rt];
                fwd_a_reg    <= wr_en && (dest == in_rs);
                fwd_b_reg    <= wr_en && (dest == in_rt);
            end else if (ex_advance) begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_advance) begin
                out_valid_reg <= 1'b1;
                retired_reg   <= retired_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            ex_word_reg <= s_instruction_word;
            ex_addr_reg <= s_instruction_address;
            fwd_val_reg <= val;
        end
        if (ex_advance) begin
            out_supported_reg <= ok;
            out_wrote_reg     <= ok && (dest != '0);
            out_dest_reg      <= dest;
            out_value_reg     <= val;
            out_next_addr_reg <= ok ? ex_addr_reg + PC_STEP : '0;
            out_retired_reg   <= retired_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_supported     = out_supported_reg;
    assign m_wrote         = out_wrote_reg;
    assign m_dest_index    = out_dest_reg;
    assign m_dest_value    = out_value_reg;
    assign m_next_address  = out_next_addr_reg;
    assign m_retired_total = out_retired_reg;

endmodule

`default_nettype wire
